### rtl/morse_text_codec_top_assert.svh
// Assertion macros used by the codec back end (mtc_back).
`ifndef MORSE_TEXT_CODEC_TOP_ASSERT_SVH
`define MORSE_TEXT_CODEC_TOP_ASSERT_SVH
`ifndef SYNTH
`define MTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`define MTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define MTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mtc_pkg.sv
package mtc_pkg;

	localparam int MAX_SYMBOLS_DEF = 5;
	localparam int NUM_CODES       = 36;
	localparam int NUM_LETTERS     = 26;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// Symbol counts and codes for a..z then 0..9, first symbol in the top bit, dash = 1
	localparam logic [2:0] CODE_LEN [NUM_CODES] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};
	localparam logic [4:0] CODE_BITS [NUM_CODES] = '{
		5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4, 5'd3,
		5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12,
		5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
	};

	// One unit of output work: a character, or symbols followed by spaces
	typedef struct packed {
		logic       is_char;
		logic [7:0] data;
		logic [2:0] sym_len;
		logic [2:0] total;
	} job_t;

	typedef struct packed {
		logic wr;
		job_t job;
	} job_req_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] len;
		logic [4:0] bits;
	} enc_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} dec_t;

	function automatic enc_t enc_lookup(input logic [7:0] b);
		enc_t       r;
		logic [7:0] c;
		logic [5:0] idx;
		logic       known;
		r     = '0;
		c     = b;
		idx   = '0;
		known = 1'b0;
		if (c inside {[8'h41:8'h5A]})
			c = c + CASE_GAP;
		if (c inside {[8'h61:8'h7A]}) begin
			known = 1'b1;
			idx   = 6'(c - CH_LOW_A);
		end else if (c inside {[8'h30:8'h39]}) begin
			known = 1'b1;
			idx   = 6'(NUM_LETTERS) + 6'(c - CH_ZERO);
		end
		if (known) begin
			r.hit  = 1'b1;
			r.len  = CODE_LEN[idx];
			r.bits = CODE_BITS[idx];
		end
		return r;
	endfunction

	function automatic dec_t dec_lookup(input logic [3:0] len, input logic [7:0] code);
		dec_t r;
		r = '0;
		for (int i = 0; i < NUM_CODES; i++) begin
			if (!r.hit && len == {1'b0, CODE_LEN[6'(i)]} && code == 8'(CODE_BITS[6'(i)])) begin
				r.hit = 1'b1;
				if (i < NUM_LETTERS)
					r.ch = CH_LOW_A + 8'(i);
				else
					r.ch = CH_ZERO + 8'(i - NUM_LETTERS);
			end
		end
		return r;
	endfunction

endpackage

### rtl/mtc_front.sv
module mtc_front #(
	parameter int MAX_SYMBOLS = mtc_pkg::MAX_SYMBOLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              direction,
	input  logic              push,
	input  logic              q_full,
	input  logic [7:0]        in_byte,
	input  logic              end_of_text,
	output mtc_pkg::job_req_t req
);

	localparam int LW = $clog2(MAX_SYMBOLS + 1);

	logic [MAX_SYMBOLS-1:0] code_q, code_n, src_code;
	logic [LW-1:0]          len_q, len_n, src_len;
	logic                   inv_q, inv_n, src_inv;
	logic                   accept, is_space, is_sym, pending, close;
	mtc_pkg::enc_t          enc;
	mtc_pkg::dec_t          dec;

	assign accept   = push && !q_full;
	assign is_space = in_byte == mtc_pkg::CH_SPACE;
	assign is_sym   = in_byte == mtc_pkg::CH_DOT || in_byte == mtc_pkg::CH_DASH;
	assign pending  = len_q != '0 || inv_q;

	// Gather symbols into the group and decide whether it closes
	always_comb begin
		code_n = code_q;
		len_n  = len_q;
		inv_n  = inv_q;
		close  = 1'b0;
		if (is_space) begin
			close = pending;
		end else if (is_sym) begin
			if (len_q < LW'(MAX_SYMBOLS)) begin
				code_n = {code_q[MAX_SYMBOLS-2:0], in_byte == mtc_pkg::CH_DASH};
				len_n  = len_q + LW'(1);
			end else begin
				inv_n = 1'b1;
			end
		end else begin
			inv_n = 1'b1;
		end
		// a space closes the current group, the end flag the updated one
		src_code = is_space ? code_q : code_n;
		src_len  = is_space ? len_q : len_n;
		src_inv  = is_space ? inv_q : inv_n;
		if (end_of_text && (len_n != '0 || inv_n))
			close = 1'b1;
		if (close) begin
			code_n = '0;
			len_n  = '0;
			inv_n  = 1'b0;
		end
	end

	assign enc = mtc_pkg::enc_lookup(in_byte);
	assign dec = mtc_pkg::dec_lookup(4'(src_len), 8'(src_code));

	// Classify the request into a job for the back end
	always_comb begin
		req     = '0;
		if (!direction) begin
			if (enc.hit) begin
				req.wr           = accept;
				req.job.data     = 8'(enc.bits);
				req.job.sym_len  = enc.len;
				req.job.total    = enc.len + 3'd1;
			end else if (is_space) begin
				req.wr           = accept;
				req.job.total    = 3'd2;
			end
		end else if (is_space && !pending) begin
			req.wr           = accept;
			req.job.is_char  = 1'b1;
			req.job.data     = mtc_pkg::CH_SPACE;
			req.job.total    = 3'd1;
		end else if (close && !src_inv && dec.hit) begin
			req.wr           = accept;
			req.job.is_char  = 1'b1;
			req.job.data     = dec.ch;
			req.job.total    = 3'd1;
		end
	end

	// Hold the group between requests; only decoding changes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			len_q  <= '0;
			inv_q  <= 1'b0;
		end else if (accept && direction) begin
			code_q <= code_n;
			len_q  <= len_n;
			inv_q  <= inv_n;
		end
	end

endmodule

### rtl/mtc_queue.sv
module mtc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  mtc_pkg::job_req_t req,
	input  logic              rd,
	output logic              full,
	output logic              empty,
	output mtc_pkg::job_t     head
);

	localparam int AW = $clog2(mtc_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(mtc_pkg::QUEUE_DEPTH + 1);

	mtc_pkg::job_t slots_q [mtc_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full  = count_q == CW'(mtc_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = req.wr && !full;
	assign do_rd = rd && !empty;
	assign head  = slots_q[rptr_q];

	// Store the job at the write pointer
	always_ff @(posedge clk) begin
		if (do_wr)
			slots_q[wptr_q] <= req.job;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == AW'(mtc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			if (do_rd)
				rptr_q <= (rptr_q == AW'(mtc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

### rtl/mtc_back.sv
`include "morse_text_codec_top_assert.svh"

module mtc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  mtc_pkg::job_t head,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          last_of_run
);

	logic [2:0] cnt_q, idx;
	logic       out_valid_q, emit, is_last;
	logic [7:0] byte_n;

	assign emit    = !q_empty && (!out_valid_q || pop);
	assign is_last = cnt_q == head.total - 3'd1;
	assign q_rd    = emit && is_last;
	assign idx     = head.sym_len - cnt_q - 3'd1;
	assign empty   = !out_valid_q;

	// Pick the byte for the current step of the job
	always_comb begin
		if (head.is_char)
			byte_n = head.data;
		else if (cnt_q < head.sym_len)
			byte_n = head.data[idx] ? mtc_pkg::CH_DASH : mtc_pkg::CH_DOT;
		else
			byte_n = mtc_pkg::CH_SPACE;
	end

	// Step through the job and fill the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			cnt_q       <= is_last ? 3'd0 : cnt_q + 3'd1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte    <= byte_n;
			last_of_run <= is_last;
		end
	end

	`MTC_ASSERT_IMPL(a_cnt_in_job, clk, arst_n, !q_empty, cnt_q < head.total, "step beyond job")
	`MTC_ASSERT_IMPL(a_job_held, clk, arst_n, cnt_q != 3'd0, !q_empty, "job lost mid-run")
	`MTC_ASSERT_IMPL(a_char_single, clk, arst_n, !q_empty && head.is_char, head.total == 3'd1,
		"character job longer than one byte")
	`MTC_ASSERT_NEXT(a_run_ends, clk, arst_n, q_rd, cnt_q == 3'd0, "counter not cleared")

endmodule

### rtl/morse_text_codec_top.sv
// Channel   Handshake          Payload
// request   push / full        in_byte[7:0], end_of_text
// result    empty / pop        out_byte[7:0], last_of_run
// config    cfg_we             cfg_wdata (direction)
//
// A request is classified in the cycle it is taken; a two-entry job queue follows.
// The back end emits one result byte per cycle unless an unpopped result holds it.
// Results per item: letter or digit len+1 (2 to 6), space 2, decoded character 1.
// Other items cause no result. full rises only when both queue slots wait.
// arst_n clears the group, queue, result valid flag and direction at once.
module morse_text_codec_top #(
	parameter int MAX_SYMBOLS = mtc_pkg::MAX_SYMBOLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic              direction_q, q_full, q_empty, q_rd;
	mtc_pkg::job_req_t req;
	mtc_pkg::job_t     head;

	// Hold the direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			direction_q <= 1'b0;
		else if (cfg_we)
			direction_q <= cfg_wdata;
	end

	assign full = q_full;

	mtc_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (direction_q),
		.push       (push),
		.q_full     (q_full),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.req        (req)
	);

	mtc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rd    (q_rd),
		.full  (q_full),
		.empty (q_empty),
		.head  (head)
	);

	mtc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

### sim/tb_morse_text_codec_top.sv
module tb_morse_text_codec_top;

	localparam int GROUP_MAX     = 5;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 80;

	// Bytes just outside the letter and digit ranges, plus the byte extremes
	localparam logic [7:0] NEAR_MISS [8] = '{
		8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h00, 8'hFF
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_item_t;

	// Track the codec state and hold the output bytes still owed
	class morse_scoreboard;
		logic       decoding;
		logic [4:0] grp_code;
		logic [2:0] grp_len;
		logic       grp_bad;
		out_item_t  due_out[$];
		int         errors;

		function new();
			decoding = 1'b0;
			grp_code = '0;
			grp_len  = '0;
			grp_bad  = 1'b0;
			errors   = 0;
		endfunction

		// {symbol count, pattern}; first symbol in the highest used bit, dash = 1
		static function logic [7:0] morse_of(input logic [7:0] c);
			case (c)
				"a": return {3'd2, 5'b00001};
				"b": return {3'd4, 5'b01000};
				"c": return {3'd4, 5'b01010};
				"d": return {3'd3, 5'b00100};
				"e": return {3'd1, 5'b00000};
				"f": return {3'd4, 5'b00010};
				"g": return {3'd3, 5'b00110};
				"h": return {3'd4, 5'b00000};
				"i": return {3'd2, 5'b00000};
				"j": return {3'd4, 5'b00111};
				"k": return {3'd3, 5'b00101};
				"l": return {3'd4, 5'b00100};
				"m": return {3'd2, 5'b00011};
				"n": return {3'd2, 5'b00010};
				"o": return {3'd3, 5'b00111};
				"p": return {3'd4, 5'b00110};
				"q": return {3'd4, 5'b01101};
				"r": return {3'd3, 5'b00010};
				"s": return {3'd3, 5'b00000};
				"t": return {3'd1, 5'b00001};
				"u": return {3'd3, 5'b00001};
				"v": return {3'd4, 5'b00001};
				"w": return {3'd3, 5'b00011};
				"x": return {3'd4, 5'b01001};
				"y": return {3'd4, 5'b01011};
				"z": return {3'd4, 5'b01100};
				"0": return {3'd5, 5'b11111};
				"1": return {3'd5, 5'b01111};
				"2": return {3'd5, 5'b00111};
				"3": return {3'd5, 5'b00011};
				"4": return {3'd5, 5'b00001};
				"5": return {3'd5, 5'b00000};
				"6": return {3'd5, 5'b10000};
				"7": return {3'd5, 5'b11000};
				"8": return {3'd5, 5'b11100};
				"9": return {3'd5, 5'b11110};
				default: return 8'h00;
			endcase
		endfunction

		function int pending();
			return due_out.size();
		endfunction

		function void add_out(input logic [7:0] ch);
			out_item_t item;
			item.ch   = ch;
			item.last = 1'b0;
			due_out.push_back(item);
		endfunction

		// Look the group up, emit its character if known, then clear it
		function void close_group();
			logic [7:0] key;
			key = {grp_len, grp_code};
			if (!grp_bad && grp_len != 0) begin
				for (int k = 0; k < 256; k++) begin
					if (morse_of(8'(k)) == key) begin
						add_out(8'(k));
						break;
					end
				end
			end
			grp_code = '0;
			grp_len  = '0;
			grp_bad  = 1'b0;
		endfunction

		function void note_request(input logic [7:0] b, input logic eot);
			logic [7:0] c;
			logic [7:0] pat;
			int         n0;
			n0 = due_out.size();
			if (!decoding) begin
				c   = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
				pat = morse_of(c);
				if (pat[7:5] != 0) begin
					for (int s = int'(pat[7:5]) - 1; s >= 0; s--)
						add_out(pat[3'(s)] ? "-" : ".");
					add_out(" ");
				end else if (c == " ") begin
					add_out(" ");
					add_out(" ");
				end
			end else begin
				if (b == " ") begin
					if (grp_len == 0 && !grp_bad)
						add_out(" ");
					else
						close_group();
				end else if (b == "." || b == "-") begin
					// drop symbols past the longest code and spoil the group
					if (grp_len < GROUP_MAX) begin
						grp_code = {grp_code[3:0], b == "-"};
						grp_len  = grp_len + 3'd1;
					end else begin
						grp_bad = 1'b1;
					end
				end else begin
					grp_bad = 1'b1;
				end
				if (eot && (grp_len != 0 || grp_bad))
					close_group();
			end
			// flag the final byte this request produced
			if (due_out.size() > n0)
				due_out[due_out.size() - 1].last = 1'b1;
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(input logic [7:0] b, input logic last);
			out_item_t want;
			if (due_out.size() == 0) begin
				report($sformatf("result byte %02h with nothing outstanding", b));
				return;
			end
			want = due_out.pop_front();
			if (b !== want.ch)
				report($sformatf("out_byte %02h, wanted %02h", b, want.ch));
			if (last !== want.last)
				report($sformatf("last_of_run %b on byte %02h, wanted %b", last, b, want.last));
		endtask
	endclass

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic [7:0] in_byte     = 8'h00;
	logic       end_of_text = 1'b0;
	logic       pop         = 1'b0;
	logic       cfg_we      = 1'b0;
	logic       cfg_wdata   = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       last_of_run;

	morse_scoreboard sb = new();

	int sent         = 0;
	int stall_cycles = 0;
	int tx_idle_pct  = 20;
	int rx_idle_pct  = 20;
	int rx_hold_len  = 0;
	bit quiet        = 1'b0;

	morse_text_codec_top #(
		.MAX_SYMBOLS(GROUP_MAX)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Note requests, check results and count cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_request(in_byte, end_of_text);
			if (pop && !empty)
				sb.check_result(out_byte, last_of_run);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles = stall_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("FAILURE");
		$finish;
	end

	// Drain results, with random stall bursts and the occasional long hold-off
	initial begin : result_sink
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_len > 0) begin
				n           = rx_hold_len;
				rx_hold_len = 0;
				repeat (n) begin
					@(negedge clk);
					pop <= 1'b0;
				end
			end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					@(negedge clk);
					pop <= 1'b0;
				end
			end else begin
				@(negedge clk);
				pop <= 1'b1;
			end
		end
	end

	task automatic sender_pause(input int n);
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	// Offer one request and hold it until taken
	task automatic send_request(input logic [7:0] b, input logic eot);
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
			sender_pause($urandom_range(1, 8));
		@(negedge clk);
		push        <= 1'b1;
		in_byte     <= b;
		end_of_text <= eot;
		sent++;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_text(input string s, input logic eot_last);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], eot_last && (i == s.len() - 1));
	endtask

	// Stop offering, wait for every owed result, then let the back end settle
	task automatic quiesce();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_direction(input logic dir);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= dir;
		@(negedge clk);
		cfg_we      <= 1'b0;
		sb.decoding  = dir;
	endtask

	function automatic logic [7:0] known_char();
		int r;
		r = $urandom_range(0, 35);
		return (r < 26) ? 8'("a" + r) : 8'("0" + r - 26);
	endfunction

	function automatic logic [7:0] foreign_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == "." || b == "-" || b == " ");
		return b;
	endfunction

	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return 8'("a" + $urandom_range(0, 25));
		else if (r < 5)
			return 8'("A" + $urandom_range(0, 25));
		else if (r < 7)
			return 8'("0" + $urandom_range(0, 9));
		else if (r == 7)
			return " ";
		else if (r == 8)
			return NEAR_MISS[3'($urandom_range(0, 7))];
		return 8'($urandom_range(0, 255));
	endfunction

	// Send one Morse group: mostly known codes, some unknown or overlong,
	// closed by a space or by the end flag on its last symbol
	task automatic send_group();
		logic [7:0] pat;
		logic [6:0] bits;
		int         len;
		int         kind;
		int         noise_at;
		logic       close_eot;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			pat  = morse_scoreboard::morse_of(known_char());
			len  = int'(pat[7:5]);
			bits = {2'b00, pat[4:0]};
		end else if (kind < 8) begin
			len  = $urandom_range(1, 5);
			bits = 7'($urandom);
		end else begin
			len  = $urandom_range(6, 7);
			bits = 7'($urandom);
		end
		noise_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
		close_eot = ($urandom_range(0, 3) == 0);
		for (int s = len - 1; s >= 0; s--) begin
			if (len - 1 - s == noise_at)
				send_request(foreign_byte(), 1'b0);
			send_request(bits[3'(s)] ? "-" : ".", (s == 0) && close_eot);
		end
		if (!close_eot)
			send_request(" ", $urandom_range(0, 5) == 0);
	endtask

	initial begin : stimulus
		int   phase_end;
		logic dir;
		bit   mid_drained;
		mid_drained = 1'b0;
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		// Encode: both cases, digit extremes, space, ignored bytes, end flag ignored
		set_direction(1'b0);
		send_text("Az09 !", 1'b0);
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b1);
		quiesce();

		// Decode: known group, lone space, overlong flushed by the end flag,
		// foreign byte, space with end flag, group held across a direction change
		set_direction(1'b1);
		send_text(".- ", 1'b0);
		send_text(" ", 1'b0);
		send_text(".....", 1'b0);
		send_request("-", 1'b1);
		send_text(".# ", 1'b0);
		send_request(" ", 1'b1);
		send_text("-.", 1'b0);
		quiesce();
		set_direction(1'b0);
		send_request("e", 1'b0);
		quiesce();
		set_direction(1'b1);
		send_request(" ", 1'b0);

		// Random phases, alternating direction
		for (int p = 0; p < 8; p++) begin
			quiesce();
			dir = 1'(p % 2);
			set_direction(dir);
			quiet       = (p == 7);
			tx_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 40);
			rx_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 40);
			// hold the receiver off so the request side fills and stalls
			if (p == 2)
				rx_hold_len = LONG_HOLD;
			phase_end = sent + (dir ? 45 : 30);
			while (sent < phase_end) begin
				if (!dir) begin
					send_request(text_byte(), $urandom_range(0, 7) == 0);
				end else begin
					case ($urandom_range(0, 9))
						0: send_request(" ", $urandom_range(0, 3) == 0);
						1: send_request(foreign_byte(), $urandom_range(0, 3) == 0);
						default: send_group();
					endcase
				end
				if (p == 4 && !mid_drained && sent >= phase_end - 15) begin
					quiesce();
					mid_drained = 1'b1;
				end
			end
		end

		quiesce();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
